### hw/rtl/psb_pkg.sv
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types and constants for the prime sieve builder.
// ----------------------------------------------------------------------------
package psb_pkg;

	localparam int LIMIT_W = 14;
	localparam int IDX_W   = 11;
	localparam int COUNT_W = 11;
	localparam int VALUE_W = 14;

	localparam int MAX_NUMBER_DEF = 16383;
	localparam int LIST_DEPTH_DEF = 2048;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10000);

	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// register index taken from the word address
	localparam logic REG_SIEVE_LIMIT = 1'b0;

	typedef enum logic {
		OP_BUILD = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_status_t;

endpackage

### hw/rtl/prime_sieve_builder.sv
// ----------------------------------------------------------------------------
// prime_sieve_builder
// Sieve of Eratosthenes with a readable list of the primes found.
//
// Request channel: in_valid/in_stall with operation and prime_index. A build
// request sieves 0..sieve_limit in the mark memory and compacts the survivors
// into the prime list; a read request returns the prime at prime_index.
// Every request gives one response on out_valid/out_stall carrying
// list_count, prime_value and found.
// For a read, the list read is registered when the request is accepted, and
// in_stall stays high until the response is loaded into the output register.
// A build runs the init sweep, the strike walk and compaction for a clamped
// limit L, stepping the mark memory through the shared adder; in_stall stays
// high meanwhile.
// sieve_limit is written over the APB port at address 0, reset 10000.
// Reset clears the prime count to zero; the memories need no clearing.
// A stalled response holds; the block keeps its next request waiting
// until the output register is free.
// ----------------------------------------------------------------------------
module prime_sieve_builder
	import psb_pkg::*;
#(
	parameter int MAX_NUMBER = MAX_NUMBER_DEF,
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [IDX_W-1:0]   prime_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COUNT_W-1:0] list_count,
	output logic [VALUE_W-1:0] prime_value,
	output logic               found
);

	localparam int LIST_W = $clog2(LIST_DEPTH);
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int IW     = (IDX_W > CNT_W) ? ((IDX_W > LIST_W) ? IDX_W : LIST_W)
	                                        : ((CNT_W > LIST_W) ? CNT_W : LIST_W);
	localparam int OW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	typedef enum logic [1:0] {
		T_IDLE,
		T_BUILD,
		T_RESP
	} state_t;

	state_t             state_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               hit_q;
	logic               out_valid_q;
	logic [COUNT_W-1:0] count_out_q;
	logic [VALUE_W-1:0] value_out_q;
	logic               found_out_q;

	eng_status_t        eng_status;
	logic [CNT_W-1:0]   eng_count;
	logic               eng_start;
	logic               list_we;
	logic [LIST_W-1:0]  list_waddr;
	logic [VALUE_W-1:0] list_wdata;
	logic               list_re;
	logic [VALUE_W-1:0] list_rdata;

	logic               accept;
	logic               out_free;
	logic               resp_load;
	logic               cfg_write;
	logic [IW-1:0]      idx_ext;
	logic [IW-1:0]      cnt_ext;
	logic               hit;
	logic [OW-1:0]      cnt_out_ext;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == REG_SIEVE_LIMIT) ? DATA_W'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_write && paddr[2] == REG_SIEVE_LIMIT) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	assign in_stall  = state_q != T_IDLE;
	assign accept    = in_valid && !in_stall;
	assign eng_start = accept && (op_t'(operation) == OP_BUILD);
	assign list_re   = accept && (op_t'(operation) == OP_READ);

	assign idx_ext = IW'(prime_index);
	assign cnt_ext = IW'(eng_count);
	assign hit     = (idx_ext < cnt_ext) && (idx_ext < IW'(LIST_DEPTH));

	assign out_free    = !out_valid_q || !out_stall;
	assign resp_load   = (state_q == T_RESP) && out_free && !eng_status.busy;
	assign cnt_out_ext = OW'(eng_count);

	psb_sieve_engine #(
		.MAX_NUMBER(MAX_NUMBER),
		.LIST_DEPTH(LIST_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (eng_start),
		.limit     (limit_q),
		.status    (eng_status),
		.count     (eng_count),
		.list_we   (list_we),
		.list_waddr(list_waddr),
		.list_wdata(list_wdata)
	);

	psb_list_ram #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_list (
		.clk  (clk),
		.we   (list_we),
		.waddr(list_waddr),
		.wdata(list_wdata),
		.re   (list_re),
		.raddr(idx_ext[LIST_W-1:0]),
		.rdata(list_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			count_out_q <= '0;
			value_out_q <= '0;
			found_out_q <= 1'b0;
		end else begin
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						if (op_t'(operation) == OP_BUILD) begin
							hit_q   <= 1'b0;
							state_q <= T_BUILD;
						end else begin
							hit_q   <= hit;
							state_q <= T_RESP;
						end
					end
				end
				T_BUILD: begin
					if (eng_status.done) begin
						state_q <= T_RESP;
					end
				end
				T_RESP: begin
					// wait for the output register to drain
					if (resp_load) begin
						count_out_q <= cnt_out_ext[COUNT_W-1:0];
						value_out_q <= hit_q ? list_rdata : '0;
						found_out_q <= hit_q;
						state_q     <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign list_count  = count_out_q;
	assign prime_value = value_out_q;
	assign found       = found_out_q;

endmodule

### hw/rtl/psb_list_ram.sv
// ----------------------------------------------------------------------------
// psb_list_ram
// Prime list storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module psb_list_ram
	import psb_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF,
	localparam int LIST_W = $clog2(LIST_DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [LIST_W-1:0]  waddr,
	input  logic [VALUE_W-1:0] wdata,
	input  logic               re,
	input  logic [LIST_W-1:0]  raddr,
	output logic [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem [LIST_DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/psb_sieve_engine.sv
// ----------------------------------------------------------------------------
// psb_sieve_engine
// Mark memory and sequencer for one sieve build. A single shared adder
// steps the init sweep, the strike walk, the square update and compaction.
// ----------------------------------------------------------------------------
module psb_sieve_engine
	import psb_pkg::*;
#(
	parameter int MAX_NUMBER = MAX_NUMBER_DEF,
	parameter int LIST_DEPTH = LIST_DEPTH_DEF,
	localparam int NUM_W  = $clog2(MAX_NUMBER + 1),
	localparam int LIST_W = $clog2(LIST_DEPTH),
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [LIMIT_W-1:0] limit,
	output eng_status_t        status,
	output logic [CNT_W-1:0]   count,
	output logic               list_we,
	output logic [LIST_W-1:0]  list_waddr,
	output logic [VALUE_W-1:0] list_wdata
);

	localparam int SUM_W = NUM_W + 1;
	localparam int LW    = (NUM_W > LIMIT_W) ? NUM_W : LIMIT_W;
	localparam int XW    = (NUM_W > VALUE_W) ? NUM_W : VALUE_W;

	typedef enum logic [3:0] {
		E_IDLE,
		E_INIT,
		E_PCHK,
		E_PWAIT,
		E_STRIKE,
		E_PNEXT,
		E_PINC,
		E_CREAD,
		E_CTEST
	} state_t;

	state_t             state_q;
	logic [NUM_W-1:0]   lim_q;
	logic [NUM_W-1:0]   p_q;
	logic [SUM_W-1:0]   sq_q;
	logic [SUM_W-1:0]   x_q;
	logic [NUM_W-1:0]   cx_q;
	logic [CNT_W-1:0]   n_q;
	logic               done_q;

	logic [LW-1:0]      lim_ext;
	logic [NUM_W-1:0]   lim_clamped;
	logic [SUM_W-1:0]   lim_wide;
	logic               x_over;

	logic [SUM_W-1:0]   add_a;
	logic [SUM_W-1:0]   add_b;
	logic [SUM_W-1:0]   add_y;

	logic               mark_mem [MAX_NUMBER + 1];
	logic               mark_we;
	logic [NUM_W-1:0]   mark_waddr;
	logic               mark_wdata;
	logic               mark_re;
	logic [NUM_W-1:0]   mark_raddr;
	logic               mark_rd_q;
	logic [XW-1:0]      cx_ext;

	// clamp the configured limit to the mark memory range
	always_comb begin
		lim_ext = LW'(limit);
		if (lim_ext > LW'(MAX_NUMBER)) begin
			lim_clamped = NUM_W'(MAX_NUMBER);
		end else begin
			lim_clamped = lim_ext[NUM_W-1:0];
		end
	end

	assign lim_wide = SUM_W'(lim_q);
	assign x_over   = x_q > lim_wide;

	// shared adder operand selection
	always_comb begin
		add_a = x_q;
		add_b = SUM_W'(1);
		unique case (state_q)
			E_STRIKE: begin
				add_b = SUM_W'(p_q);
			end
			E_PNEXT: begin
				// (p+1)^2 = p^2 + 2p + 1
				add_a = sq_q;
				add_b = {p_q, 1'b1};
			end
			E_PINC: begin
				add_a = SUM_W'(p_q);
			end
			default: begin
			end
		endcase
	end

	assign add_y = add_a + add_b;

	always_comb begin
		mark_we    = 1'b0;
		mark_waddr = x_q[NUM_W-1:0];
		mark_wdata = 1'b0;
		mark_re    = 1'b0;
		mark_raddr = x_q[NUM_W-1:0];
		unique case (state_q)
			E_INIT: begin
				mark_we    = 1'b1;
				mark_wdata = x_q >= SUM_W'(2);
			end
			E_STRIKE: begin
				mark_we = !x_over;
			end
			E_PCHK: begin
				mark_re    = 1'b1;
				mark_raddr = p_q;
			end
			E_CREAD: begin
				mark_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_waddr] <= mark_wdata;
		end
		if (mark_re) begin
			mark_rd_q <= mark_mem[mark_raddr];
		end
	end

	assign cx_ext     = XW'(cx_q);
	assign list_we    = (state_q == E_CTEST) && mark_rd_q && (n_q < CNT_W'(LIST_DEPTH));
	assign list_waddr = n_q[LIST_W-1:0];
	assign list_wdata = cx_ext[VALUE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			n_q     <= '0;
			done_q  <= 1'b0;
			lim_q   <= '0;
			p_q     <= '0;
			sq_q    <= '0;
			x_q     <= '0;
			cx_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						lim_q   <= lim_clamped;
						x_q     <= '0;
						n_q     <= '0;
						state_q <= E_INIT;
					end
				end
				E_INIT: begin
					if (x_q == lim_wide) begin
						p_q     <= NUM_W'(2);
						sq_q    <= SUM_W'(4);
						state_q <= E_PCHK;
					end else begin
						x_q <= add_y;
					end
				end
				E_PCHK: begin
					if (sq_q > lim_wide) begin
						x_q     <= SUM_W'(2);
						state_q <= E_CREAD;
					end else begin
						state_q <= E_PWAIT;
					end
				end
				E_PWAIT: begin
					if (mark_rd_q) begin
						x_q     <= sq_q;
						state_q <= E_STRIKE;
					end else begin
						state_q <= E_PNEXT;
					end
				end
				E_STRIKE: begin
					if (x_over) begin
						state_q <= E_PNEXT;
					end else begin
						x_q <= add_y;
					end
				end
				E_PNEXT: begin
					sq_q    <= add_y;
					state_q <= E_PINC;
				end
				E_PINC: begin
					p_q     <= add_y[NUM_W-1:0];
					state_q <= E_PCHK;
				end
				E_CREAD: begin
					if (x_over) begin
						done_q  <= 1'b1;
						state_q <= E_IDLE;
					end else begin
						cx_q    <= x_q[NUM_W-1:0];
						x_q     <= add_y;
						state_q <= E_CTEST;
					end
				end
				E_CTEST: begin
					if (list_we) begin
						n_q <= n_q + CNT_W'(1);
					end
					state_q <= E_CREAD;
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	assign status.busy = state_q != E_IDLE;
	assign status.done = done_q;
	assign count       = n_q;

endmodule
